@@ sv/multiplexed_adc_demod_iir_filter_macros.svh @@
// Assertion macros for the demodulator filter checker.
// No dependencies; included by files that assert.
`ifndef MULTIPLEXED_ADC_DEMOD_IIR_FILTER_MACROS_SVH
`define MULTIPLEXED_ADC_DEMOD_IIR_FILTER_MACROS_SVH

// Generic clocked assertion, disabled while in reset.
`define DMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled word keeps its valid and its data.
`define DMF_ASSERT_HOLD(lbl, vld, rdy, dat, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(dat))) else $error(msg);

`endif

@@ sv/adc_dmf_pkg.sv @@
// Shared types, constants and phase tables for the demodulator filter.
// No dependencies.
package adc_dmf_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int COEF_W            = 16;
    localparam int CH_W              = 2;
    localparam int DAC_W             = 8;
    localparam int ROM_AW            = 4;
    localparam int MEM_W             = 2 * SAMPLE_W;
    localparam int PROD_W            = 2 * SAMPLE_W;
    localparam int Q15_SHIFT         = 15;
    localparam int CFG_IDX_W         = 2;
    localparam int IN_TDATA_W        = 16;
    localparam int OUT_TDATA_W       = 80;
    localparam int PHASE_COUNT_DEF   = 12;
    localparam int NUM_CHANNELS_DEF  = 4;
    localparam int NUM_EXCITED       = 2;

    localparam logic [COEF_W-1:0] Q15_ONE       = 16'd32768;
    localparam logic [COEF_W-1:0] ALPHA_EXC_RST = 16'd32361;
    localparam logic [COEF_W-1:0] ALPHA_POT_RST = 16'd30783;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_EXCITED = 2'd0,
        CFG_ALPHA_POT     = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic             en;
        logic [CH_W-1:0]  addr;
        logic [MEM_W-1:0] data;
    } mem_wr_t;

    function automatic logic [CH_W-1:0] chan_lookup(input logic [ROM_AW-1:0] ph);
        logic [CH_W-1:0] c;
        unique case (ph)
            4'd0:    c = 2'd0;
            4'd1:    c = 2'd2;
            4'd2:    c = 2'd3;
            4'd3:    c = 2'd0;
            4'd4:    c = 2'd2;
            4'd5:    c = 2'd3;
            4'd6:    c = 2'd1;
            4'd7:    c = 2'd2;
            4'd8:    c = 2'd3;
            4'd9:    c = 2'd1;
            4'd10:   c = 2'd2;
            4'd11:   c = 2'd3;
            4'd12:   c = 2'd0;
            4'd13:   c = 2'd2;
            4'd14:   c = 2'd3;
            default: c = 2'd1;
        endcase
        return c;
    endfunction

    function automatic logic [DAC_W-1:0] dac_lookup(input logic [ROM_AW-1:0] ph);
        logic [DAC_W-1:0] d;
        unique case (ph)
            4'd0, 4'd6, 4'd12:                d = 8'd154;
            4'd1, 4'd5, 4'd7, 4'd11, 4'd13:   d = 8'd103;
            4'd2, 4'd4, 4'd8, 4'd10, 4'd14:   d = 8'd51;
            default:                          d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

@@ sv/multiplexed_adc_demod_iir_filter.sv @@
// Multiplexed converter demodulator with per-channel Q15 single-pole filters.
// Uses adc_dmf_pkg, adc_dmf_mem, adc_dmf_arith.
//
// One sample word in, one result word out. Throughput is one word per clock
// while no stall or channel wait holds. From input accept to result valid a
// word passes the memory read stage, the product stage, then sum, write back
// and output load. The channel state memory is read and written once per
// word. A word whose channel is still in the read stage, or in a stalled
// product stage, waits. This only happens when the phase table revisits a
// channel within two words. The output register lets the next word be
// accepted while a result waits. Reset clears all filter state at once.
module multiplexed_adc_demod_iir_filter
    import adc_dmf_pkg::*;
#(
    parameter int PHASE_COUNT  = PHASE_COUNT_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] raw_sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] updated_channel, [17:2] filtered_ch0, [33:18] filtered_ch1,
    // [49:34] filtered_ch2, [65:50] filtered_ch3, [67:66] next_channel,
    // [75:68] dac_code, [79:76] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEF_W-1:0]      cfg_data
);

    localparam int PH_W = $clog2(PHASE_COUNT);

    // config
    logic [COEF_W-1:0] alpha_exc_reg;
    logic [COEF_W-1:0] alpha_pot_reg;

    // phase
    logic [PH_W-1:0] phase_reg;
    logic [PH_W:0]   phase_inc;
    logic [PH_W-1:0] phase_next;
    logic [CH_W-1:0] cur_ch;
    logic            cur_exc;
    logic [COEF_W-1:0] a_sel;
    logic [COEF_W-1:0] a_clamp;

    // stage 1: memory read
    logic                s1_valid_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic                s1_exc_reg;
    logic                s1_upd_reg;
    logic [SAMPLE_W-1:0] s1_x_reg;
    logic [COEF_W-1:0]   s1_a_reg;
    logic [COEF_W-1:0]   s1_b_reg;
    logic [CH_W-1:0]     s1_nch_reg;
    logic [DAC_W-1:0]    s1_dac_reg;

    // stage 2: products
    logic                s2_valid_reg;
    logic [CH_W-1:0]     s2_ch_reg;
    logic                s2_upd_reg;
    logic [SAMPLE_W-1:0] s2_prev_reg;
    logic [CH_W-1:0]     s2_nch_reg;
    logic [DAC_W-1:0]    s2_dac_reg;

    // stage 3: output word
    logic                o_valid_reg;
    logic [CH_W-1:0]     o_upd_ch_reg;
    logic [SAMPLE_W-1:0] o_filt_reg [0:3];
    logic [CH_W-1:0]     o_nch_reg;
    logic [DAC_W-1:0]    o_dac_reg;

    logic                accept;
    logic                hazard;
    logic                s1_go;
    logic                s1_free;
    logic                s2_go;
    logic                s2_free;
    logic                o_free;

    logic [MEM_W-1:0]    rd_data;
    logic [SAMPLE_W-1:0] prev_val;
    logic [SAMPLE_W-1:0] filt_val;
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W-1:0] xin;
    logic [SAMPLE_W-1:0] res;
    mem_wr_t             wr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_exc_reg <= ALPHA_EXC_RST;
            alpha_pot_reg <= ALPHA_POT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ALPHA_EXCITED: alpha_exc_reg <= cfg_data;
                CFG_ALPHA_POT:     alpha_pot_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // phase and operand selection
    always_comb
    begin
        phase_inc  = {1'b0, phase_reg} + 1'b1;
        phase_next = (phase_inc >= (PH_W+1)'(PHASE_COUNT)) ? '0 : phase_inc[PH_W-1:0];
        cur_ch     = chan_lookup(ROM_AW'(phase_reg));
        cur_exc    = (32'(cur_ch) < NUM_EXCITED);
        a_sel      = cur_exc ? alpha_exc_reg : alpha_pot_reg;
        a_clamp    = (a_sel > Q15_ONE) ? Q15_ONE : a_sel;
    end

    // flow control
    assign o_free   = !o_valid_reg || m_tready;
    assign s2_go    = s2_valid_reg && o_free;
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_go;
    assign hazard   = (s1_valid_reg && (s1_ch_reg == cur_ch)) ||
                      (s2_valid_reg && !s2_go && (s2_ch_reg == cur_ch));
    assign s_tready = s1_free && !hazard;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_go)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg  <= cur_ch;
            s1_exc_reg <= cur_exc;
            s1_upd_reg <= (32'(cur_ch) < NUM_CHANNELS);
            s1_x_reg   <= s_tdata[SAMPLE_W-1:0];
            s1_a_reg   <= a_clamp;
            s1_b_reg   <= Q15_ONE - a_clamp;
            s1_nch_reg <= chan_lookup(ROM_AW'(phase_next));
            s1_dac_reg <= dac_lookup(ROM_AW'(phase_next));
        end
    end

    adc_dmf_mem #(
        .DEPTH (NUM_CHANNELS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cur_ch),
        .rd_data (rd_data),
        .wr      (wr)
    );

    always_comb
    begin
        prev_val = rd_data[MEM_W-1:SAMPLE_W];
        filt_val = rd_data[SAMPLE_W-1:0];
        diff     = (s1_x_reg > prev_val) ? (s1_x_reg - prev_val) : (prev_val - s1_x_reg);
        xin      = s1_exc_reg ? diff : s1_x_reg;
    end

    adc_dmf_arith u_arith (
        .clk (clk),
        .en  (s1_go),
        .y   (filt_val),
        .xin (xin),
        .a   (s1_a_reg),
        .b   (s1_b_reg),
        .res (res)
    );

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_ch_reg   <= s1_ch_reg;
            s2_upd_reg  <= s1_upd_reg;
            s2_prev_reg <= s1_exc_reg ? s1_x_reg : prev_val;
            s2_nch_reg  <= s1_nch_reg;
            s2_dac_reg  <= s1_dac_reg;
        end
    end

    always_comb
    begin
        wr.en   = s2_go && s2_upd_reg;
        wr.addr = s2_ch_reg;
        wr.data = {s2_prev_reg, res};
    end

    // output word; filtered fields mirror the store and reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_filt_reg[0] <= '0;
            o_filt_reg[1] <= '0;
            o_filt_reg[2] <= '0;
            o_filt_reg[3] <= '0;
        end
        else if (s2_go && s2_upd_reg)
        begin
            o_filt_reg[s2_ch_reg] <= res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            o_upd_ch_reg <= s2_ch_reg;
            o_nch_reg    <= s2_nch_reg;
            o_dac_reg    <= s2_dac_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {4'b0000, o_dac_reg, o_nch_reg,
                       o_filt_reg[3], o_filt_reg[2], o_filt_reg[1], o_filt_reg[0],
                       o_upd_ch_reg};

endmodule

@@ sv/adc_dmf_mem.sv @@
// Channel state memory: {previous sample, filtered value} per channel.
// Registered read with write-through; uses adc_dmf_pkg.
module adc_dmf_mem
    import adc_dmf_pkg::*;
#(
    parameter int DEPTH = NUM_CHANNELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [CH_W-1:0]  rd_addr,
    output logic [MEM_W-1:0] rd_data,
    input  mem_wr_t          wr
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [MEM_W-1:0] mem [0:DEPTH-1];
    logic [DEPTH-1:0] valid_reg;
    logic [MEM_W-1:0] rd_data_reg;
    logic             wr_hit;
    logic             wr_in_range;
    logic             rd_in_range;

    assign wr_in_range = (32'(wr.addr) < DEPTH);
    assign rd_in_range = (32'(rd_addr) < DEPTH);
    assign wr_hit      = wr.en && wr_in_range && (wr.addr == rd_addr);
    assign rd_data     = rd_data_reg;

    // entries read as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en && wr_in_range)
        begin
            valid_reg[wr.addr[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_in_range)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_hit)
            begin
                rd_data_reg <= wr.data;
            end
            else if (rd_in_range && valid_reg[rd_addr[AW-1:0]])
            begin
                rd_data_reg <= mem[rd_addr[AW-1:0]];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

endmodule

@@ sv/adc_dmf_arith.sv @@
// Q15 single-pole filter arithmetic: registered products, then sum and shift.
// Uses adc_dmf_pkg.
module adc_dmf_arith
    import adc_dmf_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [SAMPLE_W-1:0] y,
    input  logic [SAMPLE_W-1:0] xin,
    input  logic [COEF_W-1:0]   a,
    input  logic [COEF_W-1:0]   b,
    output logic [SAMPLE_W-1:0] res
);

    logic [PROD_W-1:0] pa_reg;
    logic [PROD_W-1:0] pb_reg;
    logic [PROD_W-1:0] pa_next;
    logic [PROD_W-1:0] pb_next;
    logic [PROD_W:0]   sum;

    always_comb
    begin
        pa_next = y * a;
        pb_next = xin * b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    assign sum = {1'b0, pa_reg} + {1'b0, pb_reg};
    assign res = sum[Q15_SHIFT +: SAMPLE_W];

endmodule

@@ sv/adc_dmf_checker.sv @@
// Port-level checks for the demodulator filter, bound to the top level.
// Uses adc_dmf_pkg and the assertion macros header.
`include "multiplexed_adc_demod_iir_filter_macros.svh"

module adc_dmf_checker
    import adc_dmf_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    `DMF_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, m_tdata, "result word changed while stalled")

    `DMF_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[79:76] == 4'b0000), "pad bits not zero")

    // back-to-back results: the channel updated follows the announced next channel
    `DMF_ASSERT(a_chan_seq, (m_tvalid && m_tready) ##1 (m_tvalid && m_tready) |-> (m_tdata[1:0] == $past(m_tdata[67:66])), "channel sequence broken")

endmodule

bind multiplexed_adc_demod_iir_filter adc_dmf_checker u_adc_dmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/multiplexed_adc_demod_iir_filter_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for multiplexed_adc_demod_iir_filter: random samples and coefficients,
// predicted demodulated/filtered words compared field by field. Depends on adc_dmf_pkg.
module multiplexed_adc_demod_iir_filter_tb;
    import adc_dmf_pkg::*;

    localparam int PHASE_N      = 12;
    localparam int CHANNELS     = 4;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 160;

    // channel and DAC code per phase, phase 0 in the lowest bits
    localparam logic [31:0] CHAN_SEQ = {2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3,
                                        2'd2, 2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd2, 2'd0};
    localparam logic [127:0] DAC_SEQ = {8'd0, 8'd51, 8'd103, 8'd154, 8'd103, 8'd51, 8'd0,
                                        8'd51, 8'd103, 8'd154, 8'd103, 8'd51, 8'd0, 8'd51,
                                        8'd103, 8'd154};

    // first 12 at reset coefficients, next 6 pass-through, last 6 held
    localparam logic [383:0] DIRECTED = {
        16'h5A5A, 16'hA5A5, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
        16'h5A5A, 16'hA5A5, 16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF,
        16'h0000, 16'hFFFE, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
        16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF};

    typedef struct packed {
        logic [CH_W-1:0]     updated_ch;
        logic [SAMPLE_W-1:0] filt0;
        logic [SAMPLE_W-1:0] filt1;
        logic [SAMPLE_W-1:0] filt2;
        logic [SAMPLE_W-1:0] filt3;
        logic [CH_W-1:0]     next_ch;
        logic [DAC_W-1:0]    dac_code;
    } demod_word_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COEF_W-1:0]      cfg_data = '0;

    logic [SAMPLE_W-1:0] samples_to_send[$];
    demod_word_t         predicted_words[$];
    bit                  idle_on = 1'b1;
    bit                  in_taken = 1'b0;
    int                  send_gap = 0;
    int                  stall_left = 0;
    int                  err_count = 0;
    int                  cycle_count = 0;

    // predictor state
    logic [COEF_W-1:0]   coef_exc = ALPHA_EXC_RST;
    logic [COEF_W-1:0]   coef_pot = ALPHA_POT_RST;
    logic [SAMPLE_W-1:0] filt_reg[4] = '{16'd0, 16'd0, 16'd0, 16'd0};
    logic [SAMPLE_W-1:0] prev_reg[2] = '{16'd0, 16'd0};
    logic [3:0]          phase_reg = 4'd0;

    multiplexed_adc_demod_iir_filter #(
        .PHASE_COUNT  (PHASE_N),
        .NUM_CHANNELS (CHANNELS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // coefficient above one is clamped, so the filter holds
    function automatic logic [SAMPLE_W-1:0] q15_lowpass(input logic [SAMPLE_W-1:0] y,
                                                        input logic [SAMPLE_W-1:0] x,
                                                        input logic [COEF_W-1:0] alpha);
        logic [16:0] a;
        logic [47:0] acc;
        a = (alpha > Q15_ONE) ? {1'b0, Q15_ONE} : {1'b0, alpha};
        acc = y * a + x * ({1'b0, Q15_ONE} - a);
        return acc[30:15];
    endfunction

    function automatic demod_word_t demod_step(input logic [SAMPLE_W-1:0] sample);
        demod_word_t w;
        logic [1:0]          ch;
        logic [3:0]          nxt;
        logic [SAMPLE_W-1:0] diff;
        ch = CHAN_SEQ[{phase_reg, 1'b0} +: 2];
        if (ch < 2)
        begin
            diff = (sample > prev_reg[ch]) ? sample - prev_reg[ch] : prev_reg[ch] - sample;
            filt_reg[ch] = q15_lowpass(filt_reg[ch], diff, coef_exc);
            prev_reg[ch] = sample;
        end
        else if (ch < CHANNELS)
            filt_reg[ch] = q15_lowpass(filt_reg[ch], sample, coef_pot);
        nxt = phase_reg + 4'd1;
        if (nxt >= PHASE_N || nxt == 4'd0)
            nxt = 4'd0;
        phase_reg = nxt;
        w.updated_ch = ch;
        w.filt0      = filt_reg[0];
        w.filt1      = filt_reg[1];
        w.filt2      = filt_reg[2];
        w.filt3      = (CHANNELS > 3) ? filt_reg[3] : 16'd0;
        w.next_ch    = CHAN_SEQ[{phase_reg, 1'b0} +: 2];
        w.dac_code   = DAC_SEQ[{phase_reg, 3'b000} +: 8];
        return w;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic write_coef(input cfg_idx_t idx, input logic [COEF_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ALPHA_EXCITED: coef_exc = value;
            CFG_ALPHA_POT:     coef_pot = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_tvalid || predicted_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : sample_driver
        if (rst_n && (!s_tvalid || in_taken))
        begin
            in_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 7);
                s_tvalid <= 1'b0;
            end
            else if (samples_to_send.size() != 0)
            begin
                s_tdata  <= samples_to_send.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : result_sink
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : word_checker
        demod_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
                    err_count++;
                end
                else
                begin
                    want = predicted_words.pop_front();
                    check_field("updated_channel", 16'(want.updated_ch), 16'(m_tdata[1:0]));
                    check_field("filtered_ch0", want.filt0, m_tdata[17:2]);
                    check_field("filtered_ch1", want.filt1, m_tdata[33:18]);
                    check_field("filtered_ch2", want.filt2, m_tdata[49:34]);
                    check_field("filtered_ch3", want.filt3, m_tdata[65:50]);
                    check_field("next_channel", 16'(want.next_ch), 16'(m_tdata[67:66]));
                    check_field("dac_code", 16'(want.dac_code), 16'(m_tdata[75:68]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                predicted_words.push_back(demod_step(s_tdata));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multiplexed_adc_demod_iir_filter_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [COEF_W-1:0]   exc_val;
        logic [COEF_W-1:0]   pot_val;
        logic [SAMPLE_W-1:0] last;
        int i;
        int p;
        last = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < 12; i++)
            samples_to_send.push_back(DIRECTED[i*16 +: 16]);
        wait_drained();
        write_coef(CFG_ALPHA_EXCITED, 16'd0);
        write_coef(CFG_ALPHA_POT, 16'd0);
        for (i = 12; i < 18; i++)
            samples_to_send.push_back(DIRECTED[i*16 +: 16]);
        wait_drained();
        write_coef(CFG_ALPHA_EXCITED, 16'hFFFF);
        write_coef(CFG_ALPHA_POT, 16'd32769);
        for (i = 18; i < 24; i++)
            samples_to_send.push_back(DIRECTED[i*16 +: 16]);
        wait_drained();

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: begin exc_val = Q15_ONE; pot_val = 16'd0; end
                2: begin exc_val = 16'd1; pot_val = 16'd32767; end
                3: begin exc_val = 16'd32767; pot_val = 16'd1; end
                4:
                begin
                    exc_val = 16'($urandom_range(0, 65535));
                    pot_val = 16'($urandom_range(0, 65535));
                end
                6: begin exc_val = 16'd0; pot_val = Q15_ONE; end
                7: begin exc_val = ALPHA_EXC_RST; pot_val = ALPHA_POT_RST; end
                default:
                begin
                    exc_val = 16'($urandom_range(0, 32768));
                    pot_val = 16'($urandom_range(0, 32768));
                end
            endcase
            idle_on = (p != 3 && p != 7);
            write_coef(CFG_ALPHA_EXCITED, exc_val);
            write_coef(CFG_ALPHA_POT, pot_val);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 9))
                    0: last = 16'h0000;
                    1: last = 16'hFFFF;
                    2: last = last + 16'($urandom_range(0, 64)) - 16'd32;
                    default: last = 16'($urandom_range(0, 65535));
                endcase
                samples_to_send.push_back(last);
            end
            wait_drained();
        end

        if (err_count == 0)
            $display("multiplexed_adc_demod_iir_filter_tb OK");
        else
            $display("multiplexed_adc_demod_iir_filter_tb NOT OK");
        $finish;
    end

endmodule
